// ----- sv/spism_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the SPI serial memory slave core.
package spism_pkg;

	localparam int LEN_W = 20;
	localparam int ASH_W = 24;

	// request kinds
	localparam logic [1:0] REQ_SELECT   = 2'd0;
	localparam logic [1:0] REQ_DESELECT = 2'd1;
	localparam logic [1:0] REQ_WRITE    = 2'd2;
	localparam logic [1:0] REQ_READ     = 2'd3;

	// opcodes
	localparam logic [7:0] OP_WREN  = 8'h06;
	localparam logic [7:0] OP_WRDI  = 8'h04;
	localparam logic [7:0] OP_RDSR  = 8'h05;
	localparam logic [7:0] OP_WRSR  = 8'h01;
	localparam logic [7:0] OP_READ  = 8'h03;
	localparam logic [7:0] OP_WRITE = 8'h02;
	localparam logic [7:0] OP_SLEEP = 8'hB9;
	localparam logic [7:0] OP_WAKE  = 8'hAB;

	// call status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_SEL   = 3'd1;
	localparam logic [2:0] ST_BAD_LEN   = 3'd2;
	localparam logic [2:0] ST_NOT_EN    = 3'd3;
	localparam logic [2:0] ST_RANGE     = 3'd4;
	localparam logic [2:0] ST_NONE_PEND = 3'd5;

	// pending flag bit positions
	localparam int PF_RS = 0;
	localparam int PF_RD = 1;
	localparam int PF_WD = 2;
	localparam int PF_WS = 3;

	typedef struct packed {
		logic capture;   // latch the input transfer
		logic do_sel;    // select / deselect
		logic do_wstart; // open a call if needed
		logic do_wbyte;  // process one call byte
		logic do_wend;   // close the call
		logic do_rchk;   // evaluate a read burst
		logic do_rissue; // issue one array read
		logic load_res;  // push result register to output
		logic load_mem;  // push array byte to output
	} spism_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       last_of_call;
		logic       rd_go;
		logic       rd_done;
		logic       out_free;
	} spism_sts_t;

endpackage

// ----- sv/spism_in_if.sv -----
`timescale 1ns / 1ps
// Request channel interface of the SPI serial memory slave core.
interface spism_in_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    req_type;
	logic [7:0]                    data_byte;
	logic                          first_of_call;
	logic                          last_of_call;
	logic [spism_pkg::LEN_W-1:0]   call_length;

	modport source (output valid, req_type, data_byte, first_of_call, last_of_call,
		call_length, input ready);
	modport sink (input valid, req_type, data_byte, first_of_call, last_of_call,
		call_length, output ready);
endinterface

// ----- sv/spism_out_if.sv -----
`timescale 1ns / 1ps
// Result channel interface of the SPI serial memory slave core.
interface spism_out_if;
	logic                          valid;
	logic                          ready;
	logic [7:0]                    read_byte;
	logic                          has_data;
	logic [2:0]                    status;
	logic [spism_pkg::LEN_W-1:0]   byte_count;
	logic                          last;

	modport source (output valid, read_byte, has_data, status, byte_count, last,
		input ready);
	modport sink (input valid, read_byte, has_data, status, byte_count, last,
		output ready);
endinterface

// ----- sv/spism_dp.sv -----
`timescale 1ns / 1ps
// Datapath: array, device registers, call tracking, result and output registers.
module spism_dp #(
	parameter int MEM_BYTES      = 524288,
	parameter int MAX_READ_BURST = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spism_pkg::spism_cmd_t       cmd,
	output spism_pkg::spism_sts_t       sts,
	input  logic [1:0]                  in_req_type,
	input  logic [7:0]                  in_data_byte,
	input  logic                        in_first_of_call,
	input  logic                        in_last_of_call,
	input  logic [spism_pkg::LEN_W-1:0] in_call_length,
	output logic                        out_valid,
	output logic [7:0]                  out_read_byte,
	output logic                        out_has_data,
	output logic [2:0]                  out_status,
	output logic [spism_pkg::LEN_W-1:0] out_byte_count,
	output logic                        out_last,
	input  logic                        out_ready
);
	localparam int LW = spism_pkg::LEN_W;
	localparam int AW = $clog2(MEM_BYTES);
	localparam int PW = AW + 1;
	localparam int KW = $clog2(MAX_READ_BURST + 1);
	localparam int SW = 26;
	localparam logic [SW-1:0] MEM_SZ    = SW'(MEM_BYTES);
	localparam logic [PW-1:0] MEM_P     = PW'(MEM_BYTES);
	localparam logic [LW-1:0] BURST_MAX = LW'(MAX_READ_BURST);

	// array
	logic [7:0] cell_mem_q [MEM_BYTES];
	logic [7:0] rd_data_q;

	// captured transfer
	logic [1:0]    req_q;
	logic [7:0]    data_q;
	logic          first_q;
	logic          last_q;
	logic [LW-1:0] len_q;

	// device and call state
	logic          sel_q;
	logic          wel_q;
	logic [2:0]    prot_q;  // bit0 BP0, bit1 BP1, bit2 SRWD
	logic [3:0]    pend_q;
	logic [PW-1:0] rp_q;
	logic [PW-1:0] wp_q;
	logic [7:0]    op_q;
	logic [LW-1:0] cidx_q;
	logic [23:0]   ashift_q;
	logic [2:0]    err_q;
	logic          act_q;
	logic [LW-1:0] clen_q;
	logic          ovr_q;
	logic [KW-1:0] k_q;

	// result register and output register
	logic [7:0]    res_byte_q;
	logic          res_hd_q;
	logic [2:0]    res_st_q;
	logic [LW-1:0] res_cnt_q;
	logic          ov_q;
	logic [7:0]    ob_q;
	logic          ohd_q;
	logic [2:0]    ost_q;
	logic [LW-1:0] ocnt_q;
	logic          olast_q;

	// byte step
	logic          wel_w;
	logic [2:0]    prot_w;
	logic [3:0]    pend_w;
	logic [PW-1:0] rp_w;
	logic [PW-1:0] wp_w;
	logic [7:0]    op_w;
	logic [LW-1:0] cidx_w;
	logic [23:0]   ashift_w;
	logic [2:0]    err_w;
	logic          ovr_w;
	logic          we;
	logic [23:0]   ash;
	logic [SW-1:0] wsum;
	logic [SW-1:0] asum;
	logic [2:0]    prot_d;

	// call end
	logic          end_fail;
	logic [2:0]    end_st;
	logic [LW-1:0] end_cnt;

	// read burst check
	logic [SW-1:0] rsum;
	logic          rd_go;
	logic [3:0]    rpend;
	logic [7:0]    rbyte;
	logic          rhd;
	logic [2:0]    rst;
	logic [LW-1:0] rcnt;

	assign ash    = {ashift_q[15:0], data_q};
	assign wsum   = SW'(wp_q) + SW'(clen_q);
	assign asum   = SW'(ash) + SW'(clen_q) - SW'(4);
	assign prot_d = {data_q[7], data_q[3], data_q[2]};

	always_comb begin
		wel_w    = wel_q;
		prot_w   = prot_q;
		pend_w   = pend_q;
		rp_w     = rp_q;
		wp_w     = wp_q;
		op_w     = op_q;
		cidx_w   = cidx_q;
		ashift_w = ashift_q;
		err_w    = err_q;
		ovr_w    = ovr_q;
		we       = 1'b0;
		if (clen_q != '0 && err_q == spism_pkg::ST_OK) begin
			if (cidx_q >= clen_q) begin
				ovr_w = 1'b1;
			end else if (cidx_q == '0) begin
				op_w = data_q;
				if (!sel_q) begin
					pend_w = '0;
					err_w  = spism_pkg::ST_NOT_SEL;
				end else begin
					case (data_q)
						spism_pkg::OP_WREN, spism_pkg::OP_WRDI: begin
							if (clen_q != LW'(1)) begin
								pend_w = '0;
								err_w  = spism_pkg::ST_BAD_LEN;
							end else begin
								wel_w = (data_q == spism_pkg::OP_WREN);
							end
						end
						spism_pkg::OP_RDSR: begin
							if (clen_q != LW'(1)) begin
								pend_w = '0;
								err_w  = spism_pkg::ST_BAD_LEN;
							end else begin
								pend_w = '0;
								pend_w[spism_pkg::PF_RS] = 1'b1;
							end
						end
						spism_pkg::OP_WRSR: begin
							if (!wel_q) begin
								pend_w = '0;
								err_w  = spism_pkg::ST_NOT_EN;
							end else if (clen_q == LW'(1)) begin
								pend_w = '0;
								pend_w[spism_pkg::PF_WS] = 1'b1;
							end else if (clen_q != LW'(2)) begin
								pend_w = '0;
								err_w  = spism_pkg::ST_BAD_LEN;
							end
						end
						spism_pkg::OP_READ: begin
							if (clen_q != LW'(4)) begin
								pend_w = '0;
								err_w  = spism_pkg::ST_BAD_LEN;
							end
						end
						spism_pkg::OP_WRITE: begin
							if (!wel_q) begin
								pend_w = '0;
								err_w  = spism_pkg::ST_NOT_EN;
							end else if (clen_q < LW'(4)) begin
								pend_w = '0;
								err_w  = spism_pkg::ST_BAD_LEN;
							end
						end
						spism_pkg::OP_SLEEP, spism_pkg::OP_WAKE: begin
						end
						default: begin
							// raw data call: continues a pending write or status write
							if (pend_q[spism_pkg::PF_WD]) begin
								if (wsum > MEM_SZ) begin
									pend_w = '0;
									err_w  = spism_pkg::ST_RANGE;
								end else begin
									we   = (wp_q < MEM_P);
									wp_w = wp_q + PW'(1);
								end
							end else if (pend_q[spism_pkg::PF_WS]) begin
								pend_w[spism_pkg::PF_WS] = 1'b0;
								if (clen_q != LW'(1)) begin
									pend_w = '0;
									err_w  = spism_pkg::ST_BAD_LEN;
								end else begin
									prot_w = prot_d;
								end
							end else begin
								pend_w = '0;
								err_w  = spism_pkg::ST_NONE_PEND;
							end
						end
					endcase
				end
			end else begin
				case (op_q)
					spism_pkg::OP_WRSR: begin
						if (cidx_q == LW'(1)) prot_w = prot_d;
					end
					spism_pkg::OP_READ, spism_pkg::OP_WRITE: begin
						if (cidx_q <= LW'(3)) begin
							ashift_w = ash;
							if (cidx_q == LW'(3)) begin
								if (SW'(ash) >= MEM_SZ) begin
									pend_w = '0;
									err_w  = spism_pkg::ST_RANGE;
								end else if (op_q == spism_pkg::OP_READ) begin
									rp_w   = PW'(ash);
									pend_w = '0;
									pend_w[spism_pkg::PF_RD] = 1'b1;
								end else begin
									wp_w   = PW'(ash);
									pend_w = '0;
									if (asum > MEM_SZ) begin
										err_w = spism_pkg::ST_RANGE;
									end else begin
										pend_w[spism_pkg::PF_WD] = 1'b1;
									end
								end
							end
						end else if (op_q == spism_pkg::OP_WRITE) begin
							we   = (wp_q < MEM_P);
							wp_w = wp_q + PW'(1);
						end
					end
					spism_pkg::OP_WREN, spism_pkg::OP_WRDI, spism_pkg::OP_RDSR,
					spism_pkg::OP_SLEEP, spism_pkg::OP_WAKE: begin
					end
					default: begin
						we   = (wp_q < MEM_P);
						wp_w = wp_q + PW'(1);
					end
				endcase
			end
		end
		if (cidx_q < clen_q) cidx_w = cidx_q + LW'(1);
	end

	always_comb begin
		end_fail = (clen_q != '0) && (err_q == spism_pkg::ST_OK) &&
			(ovr_q || cidx_q != clen_q);
		if (clen_q == '0) begin
			end_st = spism_pkg::ST_OK;
		end else if (end_fail) begin
			end_st = spism_pkg::ST_BAD_LEN;
		end else begin
			end_st = err_q;
		end
		end_cnt = (end_st == spism_pkg::ST_OK) ? clen_q : '0;
	end

	assign rsum = SW'(rp_q) + SW'(len_q);

	always_comb begin
		rd_go = 1'b0;
		rpend = pend_q;
		rbyte = '0;
		rhd   = 1'b0;
		rst   = spism_pkg::ST_OK;
		rcnt  = '0;
		if (len_q == '0) begin
			rst = spism_pkg::ST_OK;
		end else if (!sel_q) begin
			rpend = '0;
			rst   = spism_pkg::ST_NOT_SEL;
		end else if (pend_q[spism_pkg::PF_RS]) begin
			rpend[spism_pkg::PF_RS] = 1'b0;
			if (len_q != LW'(1)) begin
				rpend = '0;
				rst   = spism_pkg::ST_BAD_LEN;
			end else begin
				rbyte = {prot_q[2], 3'b000, prot_q[1], prot_q[0], wel_q, 1'b0};
				rhd   = 1'b1;
				rcnt  = LW'(1);
			end
		end else if (pend_q[spism_pkg::PF_RD]) begin
			if (len_q > BURST_MAX) begin
				rpend = '0;
				rst   = spism_pkg::ST_BAD_LEN;
			end else if (rsum > MEM_SZ) begin
				rpend = '0;
				rst   = spism_pkg::ST_RANGE;
			end else begin
				rd_go = 1'b1;
			end
		end else begin
			rpend = '0;
			rst   = spism_pkg::ST_NONE_PEND;
		end
	end

	// array write port
	always_ff @(posedge clk) begin
		if (cmd.do_wbyte && we) cell_mem_q[wp_q[AW-1:0]] <= data_q;
	end

	// array read port
	always_ff @(posedge clk) begin
		if (cmd.do_rissue) rd_data_q <= cell_mem_q[rp_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= in_req_type;
			data_q  <= in_data_byte;
			first_q <= in_first_of_call;
			last_q  <= in_last_of_call;
			len_q   <= in_call_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q    <= 1'b0;
			wel_q    <= 1'b0;
			prot_q   <= '0;
			pend_q   <= '0;
			rp_q     <= '0;
			wp_q     <= '0;
			op_q     <= '0;
			cidx_q   <= '0;
			ashift_q <= '0;
			err_q    <= spism_pkg::ST_OK;
			act_q    <= 1'b0;
			clen_q   <= '0;
			ovr_q    <= 1'b0;
			k_q      <= '0;
		end else begin
			if (cmd.do_sel) begin
				sel_q  <= (req_q == spism_pkg::REQ_SELECT);
				pend_q <= '0;
				act_q  <= 1'b0;
			end
			if (cmd.do_wstart && (first_q || !act_q)) begin
				act_q    <= 1'b1;
				clen_q   <= len_q;
				cidx_q   <= '0;
				err_q    <= spism_pkg::ST_OK;
				ovr_q    <= 1'b0;
				ashift_q <= '0;
			end
			if (cmd.do_wbyte) begin
				wel_q    <= wel_w;
				prot_q   <= prot_w;
				pend_q   <= pend_w;
				rp_q     <= rp_w;
				wp_q     <= wp_w;
				op_q     <= op_w;
				cidx_q   <= cidx_w;
				ashift_q <= ashift_w;
				err_q    <= err_w;
				ovr_q    <= ovr_w;
			end
			if (cmd.do_wend) begin
				act_q <= 1'b0;
				if (end_fail) begin
					pend_q <= '0;
					err_q  <= spism_pkg::ST_BAD_LEN;
				end
			end
			if (cmd.do_rchk) begin
				pend_q <= rpend;
				k_q    <= '0;
			end
			if (cmd.do_rissue) begin
				rp_q <= rp_q + PW'(1);
				k_q  <= k_q + KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_sel) begin
			res_byte_q <= '0;
			res_hd_q   <= 1'b0;
			res_st_q   <= spism_pkg::ST_OK;
			res_cnt_q  <= '0;
		end
		if (cmd.do_wend) begin
			res_byte_q <= '0;
			res_hd_q   <= 1'b0;
			res_st_q   <= end_st;
			res_cnt_q  <= end_cnt;
		end
		if (cmd.do_rchk) begin
			res_byte_q <= rbyte;
			res_hd_q   <= rhd;
			res_st_q   <= rst;
			res_cnt_q  <= rcnt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.load_res || cmd.load_mem) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			ob_q    <= res_byte_q;
			ohd_q   <= res_hd_q;
			ost_q   <= res_st_q;
			ocnt_q  <= res_cnt_q;
			olast_q <= 1'b1;
		end else if (cmd.load_mem) begin
			ob_q    <= rd_data_q;
			ohd_q   <= 1'b1;
			ost_q   <= spism_pkg::ST_OK;
			ocnt_q  <= len_q;
			olast_q <= (LW'(k_q) == len_q);
		end
	end

	assign out_valid      = ov_q;
	assign out_read_byte  = ob_q;
	assign out_has_data   = ohd_q;
	assign out_status     = ost_q;
	assign out_byte_count = ocnt_q;
	assign out_last       = olast_q;

	assign sts.req_type     = req_q;
	assign sts.last_of_call = last_q;
	assign sts.rd_go        = rd_go;
	assign sts.rd_done      = (LW'(k_q) == len_q);
	assign sts.out_free     = !ov_q || out_ready;
endmodule

// ----- sv/spism_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences each transfer through the datapath steps.
module spism_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output spism_pkg::spism_cmd_t cmd,
	input  spism_pkg::spism_sts_t sts
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DEC    = 4'd1;
	localparam logic [3:0] S_SEL    = 4'd2;
	localparam logic [3:0] S_WSTART = 4'd3;
	localparam logic [3:0] S_WBYTE  = 4'd4;
	localparam logic [3:0] S_WEND   = 4'd5;
	localparam logic [3:0] S_RCHK   = 4'd6;
	localparam logic [3:0] S_RADDR  = 4'd7;
	localparam logic [3:0] S_RDATA  = 4'd8;
	localparam logic [3:0] S_PUT    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DEC;
				end
			end
			S_DEC: begin
				case (sts.req_type)
					spism_pkg::REQ_SELECT, spism_pkg::REQ_DESELECT: state_d = S_SEL;
					spism_pkg::REQ_WRITE: state_d = S_WSTART;
					spism_pkg::REQ_READ:  state_d = S_RCHK;
					default:              state_d = S_IDLE;
				endcase
			end
			S_SEL: begin
				cmd.do_sel = 1'b1;
				state_d    = S_PUT;
			end
			S_WSTART: begin
				cmd.do_wstart = 1'b1;
				state_d       = S_WBYTE;
			end
			S_WBYTE: begin
				cmd.do_wbyte = 1'b1;
				state_d      = sts.last_of_call ? S_WEND : S_IDLE;
			end
			S_WEND: begin
				cmd.do_wend = 1'b1;
				state_d     = S_PUT;
			end
			S_RCHK: begin
				cmd.do_rchk = 1'b1;
				state_d     = sts.rd_go ? S_RADDR : S_PUT;
			end
			S_RADDR: begin
				cmd.do_rissue = 1'b1;
				state_d       = S_RDATA;
			end
			S_RDATA: begin
				if (sts.out_free) begin
					cmd.load_mem = 1'b1;
					state_d      = sts.rd_done ? S_IDLE : S_RADDR;
				end
			end
			S_PUT: begin
				if (sts.out_free) begin
					cmd.load_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ----- sv/spi_serial_memory_slave_core.sv -----
`timescale 1ns / 1ps
// Top level of the SPI serial memory slave core: slave side of a 24-bit address
// serial memory (write enable/disable, read/write status, read/write data, sleep
// and wake taken as no-ops). Requests arrive on the req channel as select,
// deselect, one host byte of a write call, or a read burst; results leave on the
// rsp channel, one per call or one per array byte of a burst, the final one
// flagged by last. Each request transfer passes through capture, decode, one to
// three datapath steps and, where it has a result, the result hand-off; a data
// read burst takes each byte as one array read followed by the hand-off of its
// registered data, and waits while the output register is still full. The output
// register holds a finished result while the next request is taken. Array
// contents are undefined until written; there is no clearing pass after reset.
// Errors clear all pending requests and force the call's byte count to zero.
module spi_serial_memory_slave_core #(
	parameter int MEM_BYTES      = 524288,
	parameter int MAX_READ_BURST = 64
) (
	input logic       clk,
	input logic       arst_n,
	spism_in_if.sink  req,
	spism_out_if.source rsp
);
	spism_pkg::spism_cmd_t cmd;
	spism_pkg::spism_sts_t sts;
	logic                  in_ready;

	// controller: one request in flight, sequenced step by step
	spism_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	assign req.ready = in_ready;

	// datapath: array, device registers, call tracking, output register
	spism_dp #(
		.MEM_BYTES      (MEM_BYTES),
		.MAX_READ_BURST (MAX_READ_BURST)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_req_type      (req.req_type),
		.in_data_byte     (req.data_byte),
		.in_first_of_call (req.first_of_call),
		.in_last_of_call  (req.last_of_call),
		.in_call_length   (req.call_length),
		.out_valid        (rsp.valid),
		.out_read_byte    (rsp.read_byte),
		.out_has_data     (rsp.has_data),
		.out_status       (rsp.status),
		.out_byte_count   (rsp.byte_count),
		.out_last         (rsp.last),
		.out_ready        (rsp.ready)
	);
endmodule

// ----- sim/tb_spi_serial_memory_slave_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the SPI serial memory slave core with a built-in behavioral predictor.
module tb_spi_serial_memory_slave_core;
	import spism_pkg::*;

	localparam int MEM_BYTES      = 524288;
	localparam int MAX_READ_BURST = 64;
	localparam int LONG_STALL     = 400;   // receiver hold-off in the back-pressure test
	localparam int DRAIN_CYCLES   = 20000; // bound on the final wait for replies
	localparam int TAIL_CYCLES    = 50;    // settle time after the last reply

	typedef logic [7:0] byte_q_t[$];

	// one request transfer
	typedef struct {
		logic [1:0]       kind;
		logic [7:0]       data;
		logic             first_b;
		logic             last_b;
		logic [LEN_W-1:0] len;
	} request_t;

	// one reply transfer
	typedef struct {
		logic [7:0]       rbyte;
		logic             has;
		logic [2:0]       st;
		logic [LEN_W-1:0] cnt;
		logic             lst;
	} reply_t;

	logic clk;
	logic arst_n;

	spism_in_if  req_ch ();
	spism_out_if rsp_ch ();

	spi_serial_memory_slave_core #(
		.MEM_BYTES     (MEM_BYTES),
		.MAX_READ_BURST(MAX_READ_BURST)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Predicted slave state, in reset condition at time zero.
	// ------------------------------------------------------------------
	logic [7:0]  mem_image [int unsigned]; // only cells the host has written
	int unsigned written_addrs[$];         // recent store addresses, used to aim reads
	bit          is_sel    = 1'b0;
	bit          wel_q     = 1'b0;
	logic [2:0]  bp_q      = 3'b000;       // {SRWD, BP1, BP0}
	logic [3:0]  pend_q    = 4'b0000;      // indexed by PF_RS, PF_RD, PF_WD, PF_WS
	int unsigned rd_ptr    = 0;
	int unsigned wr_ptr    = 0;
	logic [7:0]  op_q      = 8'h00;
	int unsigned byte_idx  = 0;
	logic [23:0] addr_acc  = 24'h0;
	logic [2:0]  call_err  = ST_OK;
	bit          in_call   = 1'b0;
	int unsigned call_len  = 0;
	bit          overrun_q = 1'b0;

	reply_t      expected_replies[$];

	// run bookkeeping
	int unsigned n_items      = 0;
	int unsigned n_replies    = 0;
	int unsigned n_data_bytes = 0;
	int unsigned fail_count   = 0;
	int unsigned status_seen [0:7];

	// idling controls shared with the receiver process
	bit src_idle  = 1'b1;
	bit snk_idle  = 1'b1;
	bit stall_req = 1'b0;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic void expect_reply(logic [7:0] rb, logic hd, logic [2:0] st,
			int unsigned cnt, logic lst);
		reply_t e;
		e.rbyte = rb;
		e.has   = hd;
		e.st    = st;
		e.cnt   = cnt[LEN_W-1:0];
		e.lst   = lst;
		expected_replies.push_back(e);
	endfunction

	// any error drops every pending request; the first error of a call sticks
	function automatic void slave_error(logic [2:0] code);
		pend_q   = '0;
		call_err = code;
	endfunction

	function automatic void slave_store(logic [7:0] d);
		if (wr_ptr < MEM_BYTES) begin
			mem_image[wr_ptr] = d;
			written_addrs.push_back(wr_ptr);
			if (written_addrs.size() > 256)
				void'(written_addrs.pop_front());
		end
		wr_ptr++;
	endfunction

	// status byte bits 2, 3 and 7 land in BP0, BP1 and SRWD
	function automatic void slave_set_protect(logic [7:0] d);
		bp_q = {d[7], d[3], d[2]};
	endfunction

	function automatic void slave_opcode_byte(logic [7:0] d);
		op_q = d;
		if (!is_sel) begin
			slave_error(ST_NOT_SEL);
			return;
		end
		case (d)
		OP_WREN: begin
			if (call_len != 1) slave_error(ST_BAD_LEN);
			else wel_q = 1'b1;
		end
		OP_WRDI: begin
			if (call_len != 1) slave_error(ST_BAD_LEN);
			else wel_q = 1'b0;
		end
		OP_RDSR: begin
			if (call_len != 1) slave_error(ST_BAD_LEN);
			else begin
				pend_q = '0;
				pend_q[PF_RS] = 1'b1;
			end
		end
		OP_WRSR: begin
			if (!wel_q) slave_error(ST_NOT_EN);
			else if (call_len == 1) begin
				// one-byte form: the data byte comes as the next call
				pend_q = '0;
				pend_q[PF_WS] = 1'b1;
			end else if (call_len != 2) slave_error(ST_BAD_LEN);
		end
		OP_READ: begin
			if (call_len != 4) slave_error(ST_BAD_LEN);
		end
		OP_WRITE: begin
			if (!wel_q) slave_error(ST_NOT_EN);
			else if (call_len < 4) slave_error(ST_BAD_LEN);
		end
		OP_SLEEP, OP_WAKE: begin
		end
		default: begin
			// unknown first byte: continues a pending write or carries status data
			if (pend_q[PF_WD]) begin
				if (longint'(wr_ptr) + longint'(call_len) > longint'(MEM_BYTES))
					slave_error(ST_RANGE);
				else
					slave_store(d);
			end else if (pend_q[PF_WS]) begin
				pend_q[PF_WS] = 1'b0;
				if (call_len != 1) slave_error(ST_BAD_LEN);
				else slave_set_protect(d);
			end else begin
				slave_error(ST_NONE_PEND);
			end
		end
		endcase
	endfunction

	function automatic void slave_body_byte(logic [7:0] d, int unsigned i);
		case (op_q)
		OP_WRSR: begin
			if (i == 1) slave_set_protect(d);
		end
		OP_READ, OP_WRITE: begin
			if (i <= 3) begin
				addr_acc = {addr_acc[15:0], d};
				if (i == 3) begin
					if (addr_acc >= MEM_BYTES) slave_error(ST_RANGE);
					else begin
						pend_q = '0;
						if (op_q == OP_READ) begin
							rd_ptr = addr_acc;
							pend_q[PF_RD] = 1'b1;
						end else begin
							wr_ptr = addr_acc;
							pend_q[PF_WD] = 1'b1;
							if (longint'(addr_acc) + longint'(call_len) - 4 >
									longint'(MEM_BYTES))
								slave_error(ST_RANGE);
						end
					end
				end
			end else if (op_q == OP_WRITE) begin
				slave_store(d);
			end
		end
		OP_WREN, OP_WRDI, OP_RDSR, OP_SLEEP, OP_WAKE: begin
		end
		default: slave_store(d);
		endcase
	endfunction

	function automatic void slave_read_burst(int unsigned len);
		if (len == 0) begin
			expect_reply(8'h00, 1'b0, ST_OK, 0, 1'b1);
		end else if (!is_sel) begin
			pend_q = '0;
			expect_reply(8'h00, 1'b0, ST_NOT_SEL, 0, 1'b1);
		end else if (pend_q[PF_RS]) begin
			pend_q[PF_RS] = 1'b0;
			if (len != 1) begin
				pend_q = '0;
				expect_reply(8'h00, 1'b0, ST_BAD_LEN, 0, 1'b1);
			end else begin
				expect_reply({bp_q[2], 3'b000, bp_q[1], bp_q[0], wel_q, 1'b0},
					1'b1, ST_OK, 1, 1'b1);
			end
		end else if (pend_q[PF_RD]) begin
			if (len > MAX_READ_BURST) begin
				pend_q = '0;
				expect_reply(8'h00, 1'b0, ST_BAD_LEN, 0, 1'b1);
			end else if (longint'(rd_ptr) + longint'(len) > longint'(MEM_BYTES)) begin
				pend_q = '0;
				expect_reply(8'h00, 1'b0, ST_RANGE, 0, 1'b1);
			end else begin
				for (int unsigned k = 0; k < len; k++)
					expect_reply(mem_image[rd_ptr + k], 1'b1, ST_OK, len, k + 1 == len);
				rd_ptr += len;
			end
		end else begin
			pend_q = '0;
			expect_reply(8'h00, 1'b0, ST_NONE_PEND, 0, 1'b1);
		end
	endfunction

	// advance the predicted state by one accepted request
	function automatic void slave_take_request(request_t r);
		case (r.kind)
		REQ_SELECT, REQ_DESELECT: begin
			is_sel  = (r.kind == REQ_SELECT);
			pend_q  = '0;
			in_call = 1'b0;
			expect_reply(8'h00, 1'b0, ST_OK, 0, 1'b1);
		end
		REQ_WRITE: begin
			// a byte with no call open starts one, like a first byte does
			if (r.first_b || !in_call) begin
				in_call   = 1'b1;
				call_len  = r.len;
				byte_idx  = 0;
				call_err  = ST_OK;
				overrun_q = 1'b0;
				addr_acc  = '0;
			end
			if (call_len != 0 && call_err == ST_OK) begin
				if (byte_idx >= call_len) overrun_q = 1'b1;
				else if (byte_idx == 0) slave_opcode_byte(r.data);
				else slave_body_byte(r.data, byte_idx);
			end
			if (byte_idx < call_len) byte_idx++;
			if (r.last_b) begin
				in_call = 1'b0;
				if (call_len == 0) begin
					expect_reply(8'h00, 1'b0, ST_OK, 0, 1'b1);
				end else begin
					if (call_err == ST_OK && (overrun_q || byte_idx != call_len))
						slave_error(ST_BAD_LEN);
					expect_reply(8'h00, 1'b0, call_err,
						(call_err == ST_OK) ? call_len : 0, 1'b1);
				end
			end
		end
		default: slave_read_burst(r.len);
		endcase
	endfunction

	// Shortens a burst that would touch never-written cells. A burst with no
	// written cell ahead becomes an over-long one, which reads nothing.
	function automatic int unsigned safe_burst_len(int unsigned want);
		int unsigned n;
		if (!is_sel || pend_q[PF_RS] || !pend_q[PF_RD] || want == 0 ||
				want > MAX_READ_BURST ||
				longint'(rd_ptr) + longint'(want) > longint'(MEM_BYTES))
			return want;
		n = 0;
		while (n < want && mem_image.exists(rd_ptr + n)) n++;
		return (n == 0) ? MAX_READ_BURST + 1 : n;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	// Called at a falling edge; returns at the falling edge after the transfer
	// with valid still high, so a back-to-back request needs no second update.
	task automatic drive_request(input logic [1:0] kind, input logic [7:0] data,
			input logic first_b, input logic last_b, input logic [LEN_W-1:0] len);
		int gap;
		request_t r;
		gap = src_idle ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.req_type      <= kind;
		req_ch.data_byte     <= data;
		req_ch.first_of_call <= first_b;
		req_ch.last_of_call  <= last_b;
		req_ch.call_length   <= len;
		r.kind    = kind;
		r.data    = data;
		r.first_b = first_b;
		r.last_b  = last_b;
		r.len     = len;
		do @(posedge clk); while (!req_ch.ready);
		slave_take_request(r);
		n_items++;
		@(negedge clk);
	endtask

	task automatic send_select(input logic [1:0] kind);
		drive_request(kind, 8'($urandom), 1'($urandom), 1'($urandom), 20'($urandom));
	endtask

	// one write call; the length rides on the first byte, later bytes carry noise there
	task automatic send_call(input byte_q_t bytes, input int unsigned announced);
		for (int i = 0; i < bytes.size(); i++)
			drive_request(REQ_WRITE, bytes[i], i == 0, i == bytes.size() - 1,
				(i == 0) ? announced[LEN_W-1:0] : 20'($urandom));
	endtask

	// the length is cut to the field width first, so the guard sees what the core sees
	task automatic send_burst(input int unsigned want);
		int unsigned len;
		len = safe_burst_len(int'(want[LEN_W-1:0]));
		drive_request(REQ_READ, 8'($urandom), 1'($urandom), 1'($urandom), len[LEN_W-1:0]);
	endtask

	task automatic wait_for_results();
		int unsigned n;
		req_ch.valid <= 1'b0;
		n = 0;
		while (expected_replies.size() != 0 && n < DRAIN_CYCLES) begin
			@(negedge clk);
			n++;
		end
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	function automatic byte_q_t op_with_addr(logic [7:0] op, logic [23:0] a);
		byte_q_t q;
		q = '{op, a[23:16], a[15:8], a[7:0]};
		return q;
	endfunction

	function automatic logic [7:0] unknown_opcode();
		logic [7:0] b;
		do b = 8'($urandom);
		while (b inside {OP_WREN, OP_WRDI, OP_RDSR, OP_WRSR, OP_READ, OP_WRITE,
			OP_SLEEP, OP_WAKE});
		return b;
	endfunction

	// mostly the true length, sometimes one off or anything at all
	function automatic int unsigned announce(int unsigned n);
		case ($urandom_range(0, 24))
		0: return n + 1;
		1: return (n > 0) ? n - 1 : 3;
		2: return $urandom_range(0, 20'hFFFFF);
		default: return n;
		endcase
	endfunction

	function automatic logic [23:0] pick_write_addr();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6) return 24'($urandom_range(0, 255));
		if (r < 8) return 24'(MEM_BYTES - $urandom_range(1, 64));
		return 24'($urandom);
	endfunction

	function automatic logic [23:0] pick_read_addr();
		if (written_addrs.size() != 0 && $urandom_range(0, 9) < 8)
			return 24'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
		return pick_write_addr();
	endfunction

	function automatic int unsigned pick_burst_len();
		case ($urandom_range(0, 19))
		0: return MAX_READ_BURST;
		1: return MAX_READ_BURST + 1;
		2: return $urandom_range(0, 20'hFFFFF);
		default: return $urandom_range(1, 16);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// everything that must be refused or ignored before a select
	task automatic test_unselected();
		send_burst(0);
		send_burst(1);
		send_call('{OP_WREN}, 1);
		send_call('{8'h00}, 0);
		send_select(REQ_DESELECT);
	endtask

	task automatic test_status_register();
		send_select(REQ_SELECT);
		send_call('{OP_WRSR, 8'hFF}, 2);       // latch still clear
		send_call('{OP_WREN}, 1);
		send_call('{OP_WRSR, 8'hFF}, 2);       // every protect bit set
		send_call('{OP_RDSR}, 1);
		send_burst(1);
		send_call('{OP_WRSR}, 1);              // one-byte form, data in its own call
		send_call('{8'h84}, 1);
		send_call('{OP_RDSR}, 1);
		send_burst(2);                         // status read must be one byte
		send_burst(1);                         // nothing left pending
		send_call('{OP_WRDI}, 1);
		send_call('{OP_RDSR}, 1);
		send_burst(1);
	endtask

	task automatic test_data_array();
		byte_q_t q;
		send_call('{OP_WREN}, 1);
		q = op_with_addr(OP_WRITE, 24'h0);
		q.push_back(8'h00);
		q.push_back(8'hFF);
		q.push_back(8'h5A);
		send_call(q, q.size());
		// last four cells of the array
		q = op_with_addr(OP_WRITE, 24'(MEM_BYTES - 4));
		q.push_back(8'hA5);
		q.push_back(8'h3C);
		q.push_back(8'hC3);
		q.push_back(8'h0F);
		send_call(q, q.size());
		send_call(op_with_addr(OP_READ, 24'h0), 4);
		send_burst(3);
		send_call(op_with_addr(OP_READ, 24'(MEM_BYTES - 4)), 4);
		send_burst(4);
		send_burst(1);                         // pointer now past the end
		send_call(op_with_addr(OP_WRITE, 24'hFFFFFF), 4);
		send_call(op_with_addr(OP_READ, 24'h0), 4);
		send_burst(MAX_READ_BURST + 1);
		send_call('{OP_SLEEP}, 1);
		send_call('{OP_WAKE}, 1);
		// header-only write, then a call whose unknown opcode byte is data too
		send_call(op_with_addr(OP_WRITE, 24'h10), 4);
		send_call('{8'h77, 8'h11}, 2);
		send_call(op_with_addr(OP_READ, 24'h10), 4);
		send_burst(2);
		send_call('{OP_WRDI}, 2);              // call ends short
		send_call('{OP_WREN, 8'h00}, 1);       // call runs over
		drive_request(REQ_WRITE, OP_WREN, 1'b0, 1'b1, 20'd1); // no first flag
		// select in the middle of a call drops it without a reply
		drive_request(REQ_WRITE, OP_WRITE, 1'b1, 1'b0, 20'd8);
		send_select(REQ_SELECT);
	endtask

	// receiver holds off while requests keep coming, so the core backs up
	task automatic test_backpressure();
		src_idle  = 1'b0;
		stall_req = 1'b1;
		send_select(REQ_SELECT);
		send_call('{OP_WREN}, 1);
		repeat (6) begin
			send_call('{OP_RDSR}, 1);
			send_burst(1);
		end
		send_call(op_with_addr(OP_READ, 24'h0), 4);
		send_burst(3);
		src_idle = 1'b1;
	endtask

	task automatic test_random_traffic(input int unsigned target);
		int unsigned start, pick, s;
		byte_q_t q;
		start = n_items;
		s = 0;
		while (n_items - start < target) begin
			// idling switches on and off in stretches, independently per side
			if (s % 10 == 0) begin
				src_idle = ($urandom_range(0, 3) != 0);
				snk_idle = ($urandom_range(0, 3) != 0);
			end
			s++;
			if (!is_sel && $urandom_range(0, 3) != 0)
				send_select(REQ_SELECT);
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_select((pick < 2) ? REQ_DESELECT : REQ_SELECT);
			end else if (pick < 18) begin
				send_call('{OP_WREN}, announce(1));
			end else if (pick < 20) begin
				send_call('{OP_WRDI}, announce(1));
			end else if (pick < 44) begin
				if (!wel_q && $urandom_range(0, 3) != 0)
					send_call('{OP_WREN}, 1);
				q = op_with_addr(OP_WRITE, pick_write_addr());
				repeat ($urandom_range(0, 8)) q.push_back(8'($urandom));
				send_call(q, announce(q.size()));
			end else if (pick < 68) begin
				send_call(op_with_addr(OP_READ, pick_read_addr()), announce(4));
				send_burst(pick_burst_len());
			end else if (pick < 76) begin
				send_call('{OP_RDSR}, announce(1));
				send_burst(($urandom_range(0, 9) < 8) ? 1 : $urandom_range(2, 4));
			end else if (pick < 82) begin
				if (!wel_q && $urandom_range(0, 3) != 0)
					send_call('{OP_WREN}, 1);
				if ($urandom_range(0, 1)) begin
					send_call('{OP_WRSR, 8'($urandom)}, announce(2));
				end else begin
					send_call('{OP_WRSR}, 1);
					send_call('{8'($urandom)}, announce(1));
				end
			end else if (pick < 88) begin
				if (!wel_q)
					send_call('{OP_WREN}, 1);
				send_call(op_with_addr(OP_WRITE, pick_write_addr()), 4);
				q = '{unknown_opcode()};
				repeat ($urandom_range(0, 6)) q.push_back(8'($urandom));
				send_call(q, announce(q.size()));
			end else if (pick < 90) begin
				send_call('{$urandom_range(0, 1) ? OP_SLEEP : OP_WAKE}, announce(1));
			end else begin
				// noise: stray bytes, stray bursts, calls cut off by a select
				case ($urandom_range(0, 2))
				0: drive_request(REQ_WRITE, 8'($urandom), 1'($urandom), 1'($urandom),
					$urandom_range(0, 1) ? 20'($urandom_range(0, 3)) : 20'($urandom));
				1: send_burst($urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom);
				default: begin
					drive_request(REQ_WRITE, OP_WRITE, 1'b1, 1'b0, 20'd6);
					send_select($urandom_range(0, 3) ? REQ_SELECT : REQ_DESELECT);
				end
				endcase
			end
		end
		src_idle = 1'b1;
		snk_idle = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Reply side: ready with random gaps, plus the long hold-off on request
	// ------------------------------------------------------------------
	initial begin : reply_drain
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (stall_req) begin
				rsp_ch.ready <= 1'b0;
				for (int c = 0; c < LONG_STALL; c++) @(negedge clk);
				stall_req = 1'b0;
			end else begin
				gap = snk_idle ? $urandom_range(0, 12) : 0;
				if (gap > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk);
			while (!(rsp_ch.valid && rsp_ch.ready) && !stall_req);
			@(negedge clk);
		end
	end

	// each reply transfer is matched against the oldest prediction
	always @(posedge clk) begin : reply_check
		reply_t got, want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.rbyte = rsp_ch.read_byte;
			got.has   = rsp_ch.has_data;
			got.st    = rsp_ch.status;
			got.cnt   = rsp_ch.byte_count;
			got.lst   = rsp_ch.last;
			n_replies++;
			if (got.has === 1'b1) n_data_bytes++;
			if (!$isunknown(got.st)) status_seen[got.st]++;
			if (expected_replies.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: unexpected reply byte %h data %b status %0d count %0d last %b",
						$time, got.rbyte, got.has, got.st, got.cnt, got.lst);
			end else begin
				want = expected_replies.pop_front();
				if (got.rbyte !== want.rbyte || got.has !== want.has || got.st !== want.st ||
						got.cnt !== want.cnt || got.lst !== want.lst) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"%0t: reply mismatch: expected byte %h data %b status %0d ",
							"count %0d last %b, got byte %h data %b status %0d count %0d last %b"},
							$time, want.rbyte, want.has, want.st, want.cnt, want.lst,
							got.rbyte, got.has, got.st, got.cnt, got.lst);
				end
			end
		end
	end

	// hard stop if the core hangs
	initial begin
		#100_000_000;
		$display("tb_spi_serial_memory_slave_core failed");
		$finish;
	end

	initial begin
		clk    = 1'b0;
		arst_n = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = REQ_SELECT;
		req_ch.data_byte     = 8'h00;
		req_ch.first_of_call = 1'b0;
		req_ch.last_of_call  = 1'b0;
		req_ch.call_length   = '0;
		rsp_ch.ready         = 1'b0;
		for (int i = 0; i < 8; i++) status_seen[i] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_unselected();
		test_status_register();
		test_data_array();
		test_backpressure();
		test_random_traffic(200);
		wait_for_results();

		if (expected_replies.size() != 0) begin
			$display("%0d predicted replies never arrived", expected_replies.size());
			fail_count += expected_replies.size();
		end
		$display("run covered %0d requests and %0d replies, %0d carrying array or status data",
			n_items, n_replies, n_data_bytes);
		$display({"reply status counts: ok %0d, not selected %0d, bad length %0d, ",
			"not enabled %0d, range %0d, nothing pending %0d"},
			status_seen[ST_OK], status_seen[ST_NOT_SEL], status_seen[ST_BAD_LEN],
			status_seen[ST_NOT_EN], status_seen[ST_RANGE], status_seen[ST_NONE_PEND]);
		if (fail_count == 0)
			$display("tb_spi_serial_memory_slave_core passed");
		else
			$display("tb_spi_serial_memory_slave_core failed");
		$finish;
	end

endmodule
